### src/vln_pkg.sv
package vln_pkg;

  localparam int unsigned CompW     = 16;
  localparam int unsigned FracW     = 15;
  localparam int unsigned LenW      = 7;
  localparam int unsigned SumW      = 37;
  localparam int unsigned RootW     = 19;
  localparam int unsigned SqrtSteps = 19;
  localparam int unsigned DivSteps  = 16;

  localparam logic [LenW-1:0] VecLenReset = 7'd64;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SQRT,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } vln_state_e;

endpackage

### src/vln_sqrt.sv
module vln_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vln_pkg::SumW-1:0]   radicand_i,
  output logic                       done_o,
  output logic [vln_pkg::RootW-1:0]  root_o
);
  import vln_pkg::*;

  logic [SumW-1:0] x_q, res_q, bit_q;
  logic [4:0]      cnt_q;
  logic            busy_q, done_q;
  logic [SumW:0]   trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 5'(SqrtSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      res_q <= '0;
      bit_q <= SumW'(1) << (SumW - 1);
      cnt_q <= '0;
    end else if (busy_q) begin
      if ({1'b0, x_q} >= trial) begin
        x_q   <= x_q - trial[SumW-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      cnt_q <= cnt_q + 5'd1;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

endmodule

### src/vln_div.sv
module vln_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vln_pkg::CompW-1:0]  mag_i,
  input  logic [vln_pkg::RootW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [vln_pkg::CompW-1:0]  quotient_o
);
  import vln_pkg::*;

  logic [RootW-1:0] rem_q;
  logic [CompW-1:0] sh_q, quo_q;
  logic [3:0]       cnt_q;
  logic             busy_q, done_q;
  logic [RootW:0]   partial;
  logic             fits;

  assign partial = {rem_q, sh_q[CompW-1]};
  assign fits    = partial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 4'(DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // The numerator is the magnitude shifted up by the fraction width, so its
  // upper bits seed the remainder and the rest enter one bit per step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RootW'(mag_i[CompW-1:1]);
      sh_q  <= {mag_i[0], {FracW{1'b0}}};
      quo_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= RootW'(partial - {1'b0, divisor_i});
      end else begin
        rem_q <= partial[RootW-1:0];
      end
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[CompW-2:0], fits};
      cnt_q <= cnt_q + 4'd1;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/vector_l2_normalizer.sv
// Components are accepted one per cycle while a vector is being collected.
// After the last component the square root runs, then each result passes through these steps:
// a store read, the operand load, 16 divider steps plus their completion and the output load.
// A zero vector skips the divider and goes from the operand load to the output load; output stalls delay each result.
// Input is held off during output, so a new vector is taken only once the last result is loaded for output.
// Reset is asynchronous and active low; it clears the control state and sets the length to 64.
module vector_l2_normalizer #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vln_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [15:0]               s_axis_tdata_i,  // [15:0] component
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [15:0]               m_axis_tdata_o,  // [15:0] unit_component
  output logic                      m_axis_tlast_o,
  output logic                      m_axis_tuser_o   // [0] zero_norm
);
  import vln_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_DIM + 1);
  localparam int unsigned AddrW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  vln_state_e state_q, state_d;

  logic [LenW-1:0]  len_q;
  logic [CntW-1:0]  eff_len;
  logic [CntW-1:0]  fill_q, n_q, idx_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [RootW-1:0] norm_q, root;
  logic             sqrt_done, div_done;
  logic [CompW-1:0] quotient;
  logic [CompW-1:0] mem [MAX_DIM];
  logic [CompW-1:0] rd_data_q;
  logic [CompW-1:0] mag;
  logic             sign_q;
  logic             zero_norm;
  logic             in_fire, complete, is_last;
  logic             div_start, emit;
  logic [CompW-1:0] q_sel, result;
  logic signed [2*CompW-1:0] square;

  logic             out_valid_q, out_last_q, out_zero_q;
  logic [CompW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= VecLenReset;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (len_q == '0) begin
      eff_len = CntW'(1);
    end else if (32'(len_q) > MAX_DIM) begin
      eff_len = CntW'(MAX_DIM);
    end else begin
      eff_len = CntW'(len_q);
    end
  end

  assign s_axis_tready_o = (state_q == ST_COLLECT);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign complete  = ({1'b0, fill_q} + 1'b1) >= {1'b0, eff_len};
  assign square    = $signed(s_axis_tdata_i) * $signed(s_axis_tdata_i);
  assign sum_d     = sum_q + SumW'($unsigned(square));
  assign zero_norm = (norm_q == '0);
  assign is_last   = (idx_q + CntW'(1) == n_q);
  assign mag       = rd_data_q[CompW-1] ? CompW'(-rd_data_q) : rd_data_q;

  vln_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .start_i    (in_fire && complete),
    .radicand_i (sum_d),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  vln_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .mag_i      (mag),
    .divisor_i  (norm_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state_q)
      ST_COLLECT: begin
        if (in_fire && complete) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (zero_norm) begin
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          emit    = 1'b1;
          state_d = is_last ? ST_COLLECT : ST_READ;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      idx_q  <= '0;
      n_q    <= '0;
    end else begin
      if (in_fire) begin
        if (complete) begin
          fill_q <= '0;
          sum_q  <= '0;
          n_q    <= fill_q + CntW'(1);
          idx_q  <= '0;
        end else begin
          fill_q <= fill_q + CntW'(1);
          sum_q  <= sum_d;
        end
      end
      if (emit && !is_last) begin
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem[fill_q[AddrW-1:0]] <= s_axis_tdata_i;
    end
    rd_data_q <= mem[idx_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sqrt_done) begin
      norm_q <= root;
    end
    if (state_q == ST_LOAD) begin
      sign_q <= rd_data_q[CompW-1];
    end
  end

  always_comb begin
    q_sel = zero_norm ? '0 : quotient;
    if (!sign_q) begin
      result = (q_sel > CompW'(32767)) ? CompW'(32767) : q_sel;
    end else begin
      result = (q_sel > CompW'(32768)) ? CompW'(32768) : CompW'(-q_sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= result;
      out_last_q <= is_last;
      out_zero_q <= zero_norm;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_zero_q;

endmodule

### src/vln_checker.sv
module vln_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [vln_pkg::LenW-1:0]  cfg_wdata_i,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [15:0]               s_axis_tdata_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [15:0]               m_axis_tdata_o,
  input logic                      m_axis_tlast_o,
  input logic                      m_axis_tuser_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A zero vector yields zero outputs.
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 16'd0)
    else $error("zero norm with nonzero output");

  // No component is taken while a vector is still being emitted.
  a_no_input_mid_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready during vector output");

  // The output of a vector only starts once input has stopped.
  a_no_output_after_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result right after input transaction");

endmodule

bind vector_l2_normalizer vln_checker u_vln_checker (.*);
